// ===== rtl/lspc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the laser scan converter.
package lspc_pkg;

    localparam int DATA_W      = 24;
    localparam int CFG_IDX_W   = 8;
    localparam int IDX_W       = 10;
    localparam int ANG_W       = 16;
    localparam int PPS_W       = 11;
    localparam int MAX_POINTS  = 1024;
    localparam int CORDIC_N    = 16;
    localparam int ITER_W      = 4;
    localparam int XY_W        = 34;
    localparam int Z_W         = 26;
    localparam int PROD_W      = 41;
    localparam int MUL_W       = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST_SCALE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PTS_SCAN   = 8'd3;

    localparam logic [23:0]      RST_DIST_SCALE = 24'd655;
    localparam logic [22:0]      RST_RANGE_MAX  = 23'd20480;
    localparam logic [ANG_W-1:0] RST_ANGLE_STEP = 16'd91;
    localparam logic [PPS_W-1:0] RST_PTS_SCAN   = 11'd361;
    localparam logic [PPS_W-1:0] PTS_LIMIT      = PPS_W'(MAX_POINTS);

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic              load;
        logic              mul_dist;
        logic              take_dist;
        logic              cord_step;
        logic [ITER_W-1:0] iter;
        logic              round;
        logic              mul_x;
        logic              mul_y;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    function automatic logic signed [Z_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
        logic signed [Z_W-1:0] r;
        unique case (i)
            4'd0:    r = 26'sd2097152;
            4'd1:    r = 26'sd1238021;
            4'd2:    r = 26'sd654136;
            4'd3:    r = 26'sd332050;
            4'd4:    r = 26'sd166669;
            4'd5:    r = 26'sd83416;
            4'd6:    r = 26'sd41718;
            4'd7:    r = 26'sd20860;
            4'd8:    r = 26'sd10430;
            4'd9:    r = 26'sd5215;
            4'd10:   r = 26'sd2608;
            4'd11:   r = 26'sd1304;
            4'd12:   r = 26'sd652;
            4'd13:   r = 26'sd326;
            4'd14:   r = 26'sd163;
            4'd15:   r = 26'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_q24(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 41'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -41'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat_q15(input logic signed [XY_W-1:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -34'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/lspc_ctrl.sv =====
// Sequencing state machine for the scan point converter.
module lspc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lspc_pkg::t_stat     i_stat,
    output lspc_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MDIST = 3'd1;
    localparam logic [2:0] S_CORD  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_MULX  = 3'd4;
    localparam logic [2:0] S_MULY  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                      r_state, n_state;
    logic [lspc_pkg::ITER_W-1:0]     r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_iter        = r_iter;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.iter    = r_iter;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MDIST;
                end
            end
            S_MDIST: begin
                o_cmd.mul_dist = 1'b1;
                n_iter         = '0;
                n_state        = S_CORD;
            end
            S_CORD: begin
                o_cmd.cord_step = 1'b1;
                o_cmd.take_dist = (r_iter == '0);
                n_iter          = r_iter + 1'b1;
                if (r_iter == lspc_pkg::ITER_W'(lspc_pkg::CORDIC_N - 1)) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_MULX;
            end
            S_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state     = S_MULY;
            end
            S_MULY: begin
                o_cmd.mul_y = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lspc_dp.sv =====
// Datapath: registers, scan counters, shared multiplier, CORDIC and output word.
module lspc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [lspc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lspc_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic signed [15:0]                  i_raw_range,
    input  logic signed [31:0]                  i_timestamp,
    input  lspc_pkg::t_cmd                      i_cmd,
    output lspc_pkg::t_stat                     o_stat,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [lspc_pkg::DATA_W-1:0]  o_distance,
    output logic signed [lspc_pkg::DATA_W-1:0]  o_x_coord,
    output logic signed [lspc_pkg::DATA_W-1:0]  o_y_coord,
    output logic                                o_valid_res,
    output logic [lspc_pkg::ANG_W-1:0]          o_beam_angle,
    output logic [lspc_pkg::IDX_W-1:0]          o_point_index,
    output logic signed [31:0]                  o_scan_time,
    output logic                                o_last_of_scan
);

    localparam int DW = lspc_pkg::DATA_W;
    localparam int XW = lspc_pkg::XY_W;
    localparam int ZW = lspc_pkg::Z_W;
    localparam int PW = lspc_pkg::PROD_W;
    localparam int MW = lspc_pkg::MUL_W;

    // configuration
    logic [23:0]                       r_dist_scale;
    logic [22:0]                       r_range_max;
    logic [lspc_pkg::ANG_W-1:0]        r_angle_step;
    logic [lspc_pkg::PPS_W-1:0]        r_pts_scan;

    // scan state
    logic [lspc_pkg::IDX_W-1:0]        r_idx;
    logic [lspc_pkg::ANG_W-1:0]        r_ang;
    logic signed [31:0]                r_time;

    // working registers
    logic signed [15:0]                r_raw;
    logic signed [PW-1:0]              r_prod;
    logic signed [DW-1:0]              r_dist;
    logic signed [DW-1:0]              r_xc;
    logic signed [XW-1:0]              r_x, r_y;
    logic signed [ZW-1:0]              r_z;
    logic                              r_flip;
    logic signed [15:0]                r_cos, r_sin;
    logic                              r_out_valid;

    logic signed [MW-1:0]              mul_a, mul_b;
    logic signed [2*MW-1:0]            mul_p;
    logic signed [ZW-1:0]              z_init;
    logic                              flip_init;
    logic signed [XW-1:0]              x_sh, y_sh, x_fin, y_fin;
    logic signed [ZW-1:0]              atan_v;
    logic signed [PW-1:0]              dist_rnd, q15_rnd;
    logic signed [XW-1:0]              cos_rnd, sin_rnd;
    logic [lspc_pkg::PPS_W-1:0]        n_eff;
    logic                              is_last;
    logic [lspc_pkg::PPS_W-1:0]        idx_inc;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_scale <= lspc_pkg::RST_DIST_SCALE;
            r_range_max  <= lspc_pkg::RST_RANGE_MAX;
            r_angle_step <= lspc_pkg::RST_ANGLE_STEP;
            r_pts_scan   <= lspc_pkg::RST_PTS_SCAN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lspc_pkg::CFG_DIST_SCALE: r_dist_scale <= i_cfg_data;
                lspc_pkg::CFG_RANGE_MAX:  r_range_max  <= i_cfg_data[22:0];
                lspc_pkg::CFG_ANGLE_STEP: r_angle_step <= i_cfg_data[lspc_pkg::ANG_W-1:0];
                lspc_pkg::CFG_PTS_SCAN:   r_pts_scan   <= i_cfg_data[lspc_pkg::PPS_W-1:0];
                default: ;
            endcase
        end
    end

    // scan length with zero and oversize clamped
    always_comb begin
        if (r_pts_scan == '0) begin
            n_eff = lspc_pkg::PPS_W'(1);
        end else if (r_pts_scan > lspc_pkg::PTS_LIMIT) begin
            n_eff = lspc_pkg::PTS_LIMIT;
        end else begin
            n_eff = r_pts_scan;
        end
        idx_inc = {1'b0, r_idx} + 1'b1;
        is_last = (idx_inc >= n_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_ang  <= '0;
            r_time <= '0;
        end else begin
            if (i_cmd.load && (r_idx == '0)) begin
                r_time <= i_timestamp;
            end
            if (i_cmd.out_load) begin
                if (is_last) begin
                    r_idx <= '0;
                    r_ang <= '0;
                end else begin
                    r_idx <= idx_inc[lspc_pkg::IDX_W-1:0];
                    r_ang <= r_ang + r_angle_step;
                end
            end
        end
    end

    // quadrant folding into the right half-plane
    always_comb begin
        z_init    = ZW'({r_ang, 8'h00});
        flip_init = 1'b0;
        unique case (r_ang[15:14]) inside
            2'b01, 2'b10: begin
                z_init    = z_init - 26'sh0800000;
                flip_init = 1'b1;
            end
            2'b11:   z_init = z_init - 26'sh1000000;
            default: ;
        endcase
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.mul_dist) begin
            mul_a = MW'(r_raw);
            mul_b = $signed({1'b0, r_dist_scale});
        end else if (i_cmd.mul_x) begin
            mul_a = MW'(r_dist);
            mul_b = MW'(r_cos);
        end else begin
            mul_a = MW'(r_dist);
            mul_b = MW'(r_sin);
        end
        mul_p = mul_a * mul_b;
    end

    assign x_sh     = r_x >>> i_cmd.iter;
    assign y_sh     = r_y >>> i_cmd.iter;
    assign atan_v   = lspc_pkg::atan_lut(i_cmd.iter);
    assign x_fin    = r_flip ? -r_x : r_x;
    assign y_fin    = r_flip ? -r_y : r_y;
    assign cos_rnd  = (x_fin + 34'sd16384) >>> 15;
    assign sin_rnd  = (y_fin + 34'sd16384) >>> 15;
    assign dist_rnd = (r_prod + 41'sd128) >>> 8;
    assign q15_rnd  = (r_prod + 41'sd16384) >>> 15;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw  <= i_raw_range;
            r_x    <= lspc_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= z_init;
            r_flip <= flip_init;
        end
        if (i_cmd.mul_dist || i_cmd.mul_x || i_cmd.mul_y) begin
            r_prod <= mul_p[PW-1:0];
        end
        if (i_cmd.take_dist) begin
            r_dist <= lspc_pkg::sat_q24(dist_rnd);
        end
        if (i_cmd.cord_step) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_v;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_v;
            end
        end
        if (i_cmd.round) begin
            r_cos <= lspc_pkg::sat_q15(cos_rnd);
            r_sin <= lspc_pkg::sat_q15(sin_rnd);
        end
        if (i_cmd.mul_y) begin
            r_xc <= lspc_pkg::sat_q24(q15_rnd);
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_distance     <= r_dist;
            o_x_coord      <= r_xc;
            o_y_coord      <= lspc_pkg::sat_q24(q15_rnd);
            o_valid_res    <= ($signed({r_dist[DW-1], r_dist}) <= $signed({2'b00, r_range_max}));
            o_beam_angle   <= r_ang;
            o_point_index  <= r_idx;
            o_scan_time    <= r_time;
            o_last_of_scan <= is_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

// ===== rtl/laser_scan_polar_to_cartesian_unit.sv =====
// Top level of the laser range scan polar to Cartesian converter.
//
//  channel  direction  handshake                   word
//  in       input      i_in_valid / o_in_ready     i_raw_range, i_timestamp
//  out      output     o_out_valid / i_out_ready   o_distance ... o_last_of_scan
//  cfg      input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  Each word passes through a multiply, 16 CORDIC iterations on one shared
//  shift-add unit, a rounding step, two multiplies and the output load.
//  A new input is taken only once the previous word is loaded at the output.
//  Synchronous active-low reset; configuration returns to defaults, counters to zero.
//  A word waiting at the output holds the next one in its final output-load step only.
module laser_scan_polar_to_cartesian_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lspc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lspc_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [15:0]                  i_raw_range,
    input  logic signed [31:0]                  i_timestamp,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [lspc_pkg::DATA_W-1:0]  o_distance,
    output logic signed [lspc_pkg::DATA_W-1:0]  o_x_coord,
    output logic signed [lspc_pkg::DATA_W-1:0]  o_y_coord,
    output logic                                o_valid_res,
    output logic [lspc_pkg::ANG_W-1:0]          o_beam_angle,
    output logic [lspc_pkg::IDX_W-1:0]          o_point_index,
    output logic signed [31:0]                  o_scan_time,
    output logic                                o_last_of_scan
);

    lspc_pkg::t_cmd  cmd;
    lspc_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    lspc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lspc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_raw_range    (i_raw_range),
        .i_timestamp    (i_timestamp),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_distance     (o_distance),
        .o_x_coord      (o_x_coord),
        .o_y_coord      (o_y_coord),
        .o_valid_res    (o_valid_res),
        .o_beam_angle   (o_beam_angle),
        .o_point_index  (o_point_index),
        .o_scan_time    (o_scan_time),
        .o_last_of_scan (o_last_of_scan)
    );

endmodule

// ===== rtl/lspc_chk.sv =====
// Port-level checks for the scan converter, bound to the top level.
module lspc_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [lspc_pkg::DATA_W-1:0]  o_distance,
    input logic signed [lspc_pkg::DATA_W-1:0]  o_x_coord,
    input logic signed [lspc_pkg::DATA_W-1:0]  o_y_coord,
    input logic [lspc_pkg::ANG_W-1:0]          o_beam_angle,
    input logic [lspc_pkg::IDX_W-1:0]          o_point_index,
    input logic                                o_last_of_scan
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_distance)
            && $stable(o_x_coord) && $stable(o_y_coord))
        else $error("output word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again while a word is in flight");

    a_top_index_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_point_index == '1) |-> o_last_of_scan)
        else $error("highest index not marked as end of scan");

    a_first_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_point_index == '0) |-> (o_beam_angle == '0))
        else $error("first point of a scan has non-zero angle");

endmodule

bind laser_scan_polar_to_cartesian_unit lspc_chk u_lspc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_distance     (o_distance),
    .o_x_coord      (o_x_coord),
    .o_y_coord      (o_y_coord),
    .o_beam_angle   (o_beam_angle),
    .o_point_index  (o_point_index),
    .o_last_of_scan (o_last_of_scan)
);
